// File: design/get_pkg.sv
// ----------------------------------------------------------------------------
// get_pkg
// Shared types and constants for the gradient edge threshold block.
// ----------------------------------------------------------------------------
package get_pkg;

    localparam int PIXEL_W = 8;
    localparam int COORD_W = 11;
    localparam int THR_SQ_W = 16;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [7:0] THRESHOLD_RST = 8'd20;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RST = 12'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [PIXEL_W-1:0] EDGE_ON = 8'd255;
    localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

    // per-pixel position flags from the scan counters
    typedef struct packed {
        logic emit;     // a result is produced for this pixel
        logic border;   // reported position lies on the border
        logic last_px;  // last result of the frame
        logic wrap;     // pixel closes a row
    } scan_flags_t;

endpackage

// File: design/get_line_ram.sv
// ----------------------------------------------------------------------------
// get_line_ram
// One-line pixel memory: one write port, one registered read port,
// read returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module get_line_ram #(
    parameter int DEPTH = 2048,
    parameter int AW = 11,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/get_scan.sv
// ----------------------------------------------------------------------------
// get_scan
// Raster row/column counters with size saturation and position flags.
// ----------------------------------------------------------------------------
module get_scan #(
    parameter int CW = 11,
    parameter int RW = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [CW:0]               width_lim,
    input  logic [RW:0]               height_lim,
    output logic [CW-1:0]             col_cur,
    output logic [CW-1:0]             col_ahead,
    output logic [get_pkg::COORD_W-1:0] out_row,
    output logic [get_pkg::COORD_W-1:0] out_col,
    output get_pkg::scan_flags_t      flags
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW:0]   w_m1;
    logic [RW:0]   h_m1;
    logic [RW-1:0] row_cur;
    logic [RW-1:0] row_rep;
    logic          row_end;
    logic [RW+get_pkg::COORD_W-1:0] row_ext;
    logic [CW+get_pkg::COORD_W-1:0] col_ext;

    always_comb begin
        w_m1 = width_lim - (CW+1)'(1);
        h_m1 = height_lim - (RW+1)'(1);
        col_cur = ({1'b0, col_reg} > w_m1) ? w_m1[CW-1:0] : col_reg;
        row_cur = ({1'b0, row_reg} > h_m1) ? h_m1[RW-1:0] : row_reg;
        col_ahead = col_cur + CW'(1);
        row_rep = row_cur - RW'(1);
        row_end = ({1'b0, row_cur} == h_m1);
        flags.wrap = ({1'b0, col_cur} == w_m1);
        flags.emit = (row_cur != '0);
        flags.border = (row_cur == RW'(1)) || (col_cur == '0) || flags.wrap;
        flags.last_px = row_end && flags.wrap;
        row_ext = {{get_pkg::COORD_W{1'b0}}, row_rep};
        col_ext = {{get_pkg::COORD_W{1'b0}}, col_cur};
        out_row = row_ext[get_pkg::COORD_W-1:0];
        out_col = col_ext[get_pkg::COORD_W-1:0];
        if (flags.wrap) begin
            col_next = '0;
            row_next = row_end ? '0 : row_cur + RW'(1);
        end else begin
            col_next = col_ahead;
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: design/get_edge.sv
// ----------------------------------------------------------------------------
// get_edge
// Gradient stage: takes line-buffer read data, forms the squared gradient,
// compares to threshold squared, writes back the upper line, and holds the
// output transaction register.
// ----------------------------------------------------------------------------
module get_edge #(
    parameter int AW = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  get_pkg::scan_flags_t          flags,
    input  logic [AW-1:0]                 col_addr,
    input  logic [get_pkg::COORD_W-1:0]   out_row,
    input  logic [get_pkg::COORD_W-1:0]   out_col,
    input  logic [get_pkg::PIXEL_W-1:0]   pixel,
    input  logic [get_pkg::PIXEL_W-1:0]   mid_center,
    input  logic [get_pkg::PIXEL_W-1:0]   mid_right,
    input  logic [get_pkg::PIXEL_W-1:0]   upper_center,
    input  logic [get_pkg::THR_SQ_W-1:0]  thr_sq,
    output logic                          s_ready,
    output logic                          upper_we,
    output logic [AW-1:0]                 upper_waddr,
    output logic [get_pkg::PIXEL_W-1:0]   upper_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [get_pkg::PIXEL_W-1:0]   m_edge,
    output logic [get_pkg::COORD_W-1:0]   m_row,
    output logic [get_pkg::COORD_W-1:0]   m_col,
    output logic                          m_last
);

    logic                         s1_valid_reg;
    get_pkg::scan_flags_t         s1_flags_reg;
    logic [AW-1:0]                s1_addr_reg;
    logic [get_pkg::COORD_W-1:0]  s1_row_reg, s1_col_reg;
    logic [get_pkg::PIXEL_W-1:0]  s1_px_reg;
    logic [get_pkg::PIXEL_W-1:0]  left_reg;

    logic                         m_valid_reg;
    logic [get_pkg::PIXEL_W-1:0]  m_edge_reg;
    logic [get_pkg::COORD_W-1:0]  m_row_reg, m_col_reg;
    logic                         m_last_reg;

    logic        out_ok, s1_go, advance;
    logic [6:0]  gx_abs, gy_abs;
    logic [13:0] gx_sq, gy_sq;
    logic [14:0] mag;
    logic        is_edge;

    always_comb begin
        out_ok = !m_valid_reg || m_ready;
        s1_go = !s1_flags_reg.emit || out_ok;
        advance = s1_valid_reg && s1_go;
        s_ready = !s1_valid_reg || s1_go;

        gx_abs = (mid_right[7:1] >= left_reg[7:1]) ? mid_right[7:1] - left_reg[7:1]
                                                   : left_reg[7:1] - mid_right[7:1];
        gy_abs = (upper_center[7:1] >= s1_px_reg[7:1])
               ? upper_center[7:1] - s1_px_reg[7:1]
               : s1_px_reg[7:1] - upper_center[7:1];
        gx_sq = 14'(gx_abs) * 14'(gx_abs);
        gy_sq = 14'(gy_abs) * 14'(gy_abs);
        mag = {1'b0, gx_sq} + {1'b0, gy_sq};
        is_edge = !s1_flags_reg.border && ({1'b0, mag} > thr_sq);
    end

    assign upper_we = advance;
    assign upper_waddr = s1_addr_reg;
    assign upper_wdata = mid_center;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            left_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                left_reg <= s1_flags_reg.wrap ? '0 : mid_center;
            end
            if (advance && s1_flags_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_flags_reg <= flags;
            s1_addr_reg <= col_addr;
            s1_row_reg <= out_row;
            s1_col_reg <= out_col;
            s1_px_reg <= pixel;
        end
        if (advance && s1_flags_reg.emit) begin
            m_edge_reg <= is_edge ? get_pkg::EDGE_ON : get_pkg::EDGE_OFF;
            m_row_reg <= s1_row_reg;
            m_col_reg <= s1_col_reg;
            m_last_reg <= s1_flags_reg.last_px;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_edge = m_edge_reg;
    assign m_row = m_row_reg;
    assign m_col = m_col_reg;
    assign m_last = m_last_reg;

endmodule

// File: design/gradient_edge_threshold.sv
// ----------------------------------------------------------------------------
// gradient_edge_threshold
// Streaming central-difference edge detector with squared-magnitude threshold.
// ----------------------------------------------------------------------------
// Takes one grayscale pixel per clock in raster order (while result back-pressure
// does not stall input) and returns, for every pixel from the second row on, the
// edge decision for the pixel above it in its column (edge 255, else 0; border
// positions give 0; the bottom row is not reported). The line RAMs are read at
// input acceptance; a result passes the stage register and then the output
// register. The line RAMs need no clearing after reset. Configuration
// registers: 0 threshold, 1 frame width, 2 frame height; sizes are saturated to
// 3..MAX_WIDTH and 3..MAX_HEIGHT.
module gradient_edge_threshold #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // [7:0] edge_value, [18:8] out_row,
                                        // [29:19] out_col, [31:30] zero
    output logic        m_tlast,        // last_of_frame
    input  logic        cfg_wr_en,
    input  logic [get_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [get_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LWW = (CW + 1 > get_pkg::CFG_DATA_W) ? CW + 1 : get_pkg::CFG_DATA_W;
    localparam int LWH = (RW + 1 > get_pkg::CFG_DATA_W) ? RW + 1 : get_pkg::CFG_DATA_W;

    logic [get_pkg::THR_SQ_W-1:0]   thr_sq_reg;
    logic [get_pkg::CFG_DATA_W-1:0] width_reg, height_reg;
    logic [LWW-1:0] width_ext, width_sat;
    logic [LWH-1:0] height_ext, height_sat;
    logic [CW:0]    width_lim;
    logic [RW:0]    height_lim;

    logic                          accept;
    logic [CW-1:0]                 col_cur, col_ahead;
    logic [get_pkg::COORD_W-1:0]   scan_row, scan_col;
    get_pkg::scan_flags_t          scan_flags;

    logic [7:0]    mid_center, mid_right, upper_center;
    logic          upper_we;
    logic [CW-1:0] upper_waddr;
    logic [7:0]    upper_wdata;
    logic [7:0]    edge_value;
    logic [get_pkg::COORD_W-1:0] res_row, res_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg <= get_pkg::THR_SQ_W'(get_pkg::THRESHOLD_RST)
                        * get_pkg::THR_SQ_W'(get_pkg::THRESHOLD_RST);
            width_reg <= get_pkg::WIDTH_RST;
            height_reg <= get_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                get_pkg::REG_THRESHOLD: begin
                    thr_sq_reg <= get_pkg::THR_SQ_W'(cfg_wr_data[7:0])
                                * get_pkg::THR_SQ_W'(cfg_wr_data[7:0]);
                end
                get_pkg::REG_WIDTH: begin
                    width_reg <= cfg_wr_data;
                end
                get_pkg::REG_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        width_ext = LWW'(width_reg);
        height_ext = LWH'(height_reg);
        if (width_ext < LWW'(3)) begin
            width_sat = LWW'(3);
        end else if (width_ext > LWW'(MAX_WIDTH)) begin
            width_sat = LWW'(MAX_WIDTH);
        end else begin
            width_sat = width_ext;
        end
        if (height_ext < LWH'(3)) begin
            height_sat = LWH'(3);
        end else if (height_ext > LWH'(MAX_HEIGHT)) begin
            height_sat = LWH'(MAX_HEIGHT);
        end else begin
            height_sat = height_ext;
        end
        width_lim = width_sat[CW:0];
        height_lim = height_sat[RW:0];
    end

    assign accept = s_tvalid && s_tready;

    get_scan #(
        .CW(CW),
        .RW(RW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .col_cur    (col_cur),
        .col_ahead  (col_ahead),
        .out_row    (scan_row),
        .out_col    (scan_col),
        .flags      (scan_flags)
    );

    // middle line kept twice so that columns c and c+1 are read together
    get_line_ram #(
        .DEPTH(MAX_WIDTH),
        .AW(CW),
        .DW(8)
    ) u_mid_center (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_cur),
        .wdata (s_tdata),
        .re    (accept),
        .raddr (col_cur),
        .rdata (mid_center)
    );

    get_line_ram #(
        .DEPTH(MAX_WIDTH),
        .AW(CW),
        .DW(8)
    ) u_mid_right (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_cur),
        .wdata (s_tdata),
        .re    (accept),
        .raddr (col_ahead),
        .rdata (mid_right)
    );

    get_line_ram #(
        .DEPTH(MAX_WIDTH),
        .AW(CW),
        .DW(8)
    ) u_upper (
        .aclk  (aclk),
        .we    (upper_we),
        .waddr (upper_waddr),
        .wdata (upper_wdata),
        .re    (accept),
        .raddr (col_cur),
        .rdata (upper_center)
    );

    get_edge #(
        .AW(CW)
    ) u_edge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .flags        (scan_flags),
        .col_addr     (col_cur),
        .out_row      (scan_row),
        .out_col      (scan_col),
        .pixel        (s_tdata),
        .mid_center   (mid_center),
        .mid_right    (mid_right),
        .upper_center (upper_center),
        .thr_sq       (thr_sq_reg),
        .s_ready      (s_tready),
        .upper_we     (upper_we),
        .upper_waddr  (upper_waddr),
        .upper_wdata  (upper_wdata),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_edge       (edge_value),
        .m_row        (res_row),
        .m_col        (res_col),
        .m_last       (m_tlast)
    );

    assign m_tdata = {2'b00, res_col, res_row, edge_value};

endmodule

// File: dv/get_edge_checker.sv
// ----------------------------------------------------------------------------
// get_edge_checker
// Watches the pixel, result and register ports of the edge detector, keeps
// its own copy of the line buffers and scan counters, predicts every edge
// result and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module get_edge_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [31:0]                    m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [get_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [get_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int unsigned                    fail_count,
    output int unsigned                    pending,
    output int unsigned                    checked
);

    localparam int MAX_DIM = 2048;

    typedef struct packed {
        logic [get_pkg::PIXEL_W-1:0] edge_value;
        logic [get_pkg::COORD_W-1:0] out_row;
        logic [get_pkg::COORD_W-1:0] out_col;
        logic                        last_of_frame;
    } edge_result_t;

    logic [7:0]                   thr_cfg;
    logic [11:0]                  width_cfg;
    logic [11:0]                  height_cfg;
    logic [7:0]                   upper_line [MAX_DIM];
    logic [7:0]                   middle_line [MAX_DIM];
    logic [7:0]                   left_pix;
    logic [get_pkg::COORD_W-1:0]  row_pos;
    logic [get_pkg::COORD_W-1:0]  col_pos;
    edge_result_t                 edge_q [$];
    edge_result_t                 want;
    int unsigned                  n_fail;
    int unsigned                  n_checked;

    initial begin
        for (int i = 0; i < MAX_DIM; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        n_fail = 0;
        n_checked = 0;
        fail_count = 0;
        pending = 0;
        checked = 0;
    end

    function automatic int clamp_dim(input logic [11:0] v);
        if (v < 12'd3) return 3;
        if (v > 12'd2048) return MAX_DIM;
        return int'(v);
    endfunction

    task automatic predict_pixel(input logic [7:0] px);
        int           w;
        int           h;
        int           r;
        int           c;
        int           orow;
        int           gx;
        int           gy;
        logic [7:0]   old_mid;
        edge_result_t res;
        w = clamp_dim(width_cfg);
        h = clamp_dim(height_cfg);
        // a shrunk frame pulls the scan position back onto its last row/column
        r = (int'(row_pos) > h - 1) ? h - 1 : int'(row_pos);
        c = (int'(col_pos) > w - 1) ? w - 1 : int'(col_pos);
        old_mid = middle_line[c];
        if (r >= 1) begin
            orow = r - 1;
            res.edge_value = get_pkg::EDGE_OFF;
            if (orow >= 1 && c >= 1 && c + 1 < w) begin
                gx = int'(middle_line[c + 1] >> 1) - int'(left_pix >> 1);
                gy = int'(upper_line[c] >> 1) - int'(px >> 1);
                if (gx * gx + gy * gy > int'(thr_cfg) * int'(thr_cfg))
                    res.edge_value = get_pkg::EDGE_ON;
            end
            res.out_row = orow[get_pkg::COORD_W-1:0];
            res.out_col = c[get_pkg::COORD_W-1:0];
            res.last_of_frame = (r == h - 1) && (c == w - 1);
            edge_q.push_back(res);
        end
        left_pix = old_mid;
        upper_line[c] = old_mid;
        middle_line[c] = px;
        if (c >= w - 1) begin
            c = 0;
            left_pix = '0;
            r = (r >= h - 1) ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
        row_pos = r[get_pkg::COORD_W-1:0];
        col_pos = c[get_pkg::COORD_W-1:0];
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_cfg = get_pkg::THRESHOLD_RST;
            width_cfg = get_pkg::WIDTH_RST;
            height_cfg = get_pkg::HEIGHT_RST;
            left_pix = '0;
            row_pos = '0;
            col_pos = '0;
            edge_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    get_pkg::REG_THRESHOLD: thr_cfg = cfg_wr_data[7:0];
                    get_pkg::REG_WIDTH:     width_cfg = cfg_wr_data;
                    get_pkg::REG_HEIGHT:    height_cfg = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (edge_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result, expected none, got tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = edge_q.pop_front();
                    n_checked++;
                    check_field("edge_value", 32'(want.edge_value), 32'(m_tdata[7:0]));
                    check_field("out_row", 32'(want.out_row), 32'(m_tdata[18:8]));
                    check_field("out_col", 32'(want.out_col), 32'(m_tdata[29:19]));
                    check_field("last_of_frame", 32'(want.last_of_frame), 32'(m_tlast));
                end
            end
        end
        fail_count <= n_fail;
        pending <= edge_q.size();
        checked <= n_checked;
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the gradient edge threshold block: a short fixed
// frame, then random frames over many sizes and thresholds, mid-frame size
// reductions and clamped small sizes, with random idling on both streams and
// long result back-pressure; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          LAT_GAP = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam longint      RUN_LIMIT = 30_000_000;
    localparam logic [get_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // 5x4 probe frame, first pixel in the low byte
    localparam logic [159:0] PROBE = {
        8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF,
        8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_wr_en;
    logic [get_pkg::CFG_IDX_W-1:0]  cfg_wr_index;
    logic [get_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned pixels_sent;
    int unsigned results_taken;
    int unsigned phases;
    int unsigned calm [2];
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned pix_mode;
    logic [7:0]  base_level;

    gradient_edge_threshold DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    get_edge_checker edge_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #(RUN_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // side 0 is the pixel stream, side 1 the result stream
    function automatic int unsigned next_gap(input int side);
        if (calm[side] > 0) begin
            calm[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm[side] = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic int unsigned eff_size(input logic [11:0] v);
        if (v < 12'd3) return 3;
        if (v > 12'd2048) return 2048;
        return 32'(v);
    endfunction

    function automatic logic [7:0] next_pixel();
        logic [7:0] step;
        case (pix_mode)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: begin
                step = 8'($urandom_range(0, 6));
                base_level = base_level + step - 8'd3;
                step = 8'($urandom_range(0, 40));
                return base_level + step;
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int unsigned gap;
        gap = next_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(next_pixel());
    endtask

    // drop valid, drain every expected result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (LAT_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [get_pkg::CFG_IDX_W-1:0] idx,
                             input logic [11:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [11:0] w,
                              input logic [11:0] h);
        logic [3:0] junk;
        junk = 4'($urandom_range(0, 15));
        write_reg(get_pkg::REG_THRESHOLD, {junk, thr});
        write_reg(get_pkg::REG_WIDTH, w);
        write_reg(get_pkg::REG_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        cur_w = eff_size(w);
        cur_h = eff_size(h);
        phases++;
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned start;
        int unsigned frames;
        int unsigned k;
        int unsigned r;
        int unsigned c;
        logic [7:0]  thr;
        logic [11:0] w;
        logic [11:0] h;
        start = pixels_sent;
        while (pixels_sent - start < goal) begin
            case ($urandom_range(0, 5))
                0: thr = 8'd0;
                1: thr = 8'hFF;
                2: thr = 8'($urandom_range(0, 255));
                default: thr = 8'($urandom_range(1, 60));
            endcase
            w = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                            : 12'($urandom_range(3, 12));
            h = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                            : 12'($urandom_range(3, 7));
            pix_mode = $urandom_range(0, 2);
            base_level = 8'($urandom_range(0, 255));
            set_config(thr, w, h);
            if ($urandom_range(0, 3) == 0) begin
                // stop inside a frame and shrink it while idle
                k = $urandom_range(1, cur_w * cur_h - 1);
                send_random_pixels(k);
                settle();
                r = k / cur_w;
                c = k % cur_w;
                w = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 2))
                                                : 12'($urandom_range(3, cur_w));
                h = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 2))
                                                : 12'($urandom_range(3, cur_h));
                set_config(8'($urandom_range(0, 80)), w, h);
                if (r > cur_h - 1) r = cur_h - 1;
                if (c > cur_w - 1) c = cur_w - 1;
                send_random_pixels((cur_h - 1 - r) * cur_w + (cur_w - c));
            end
            frames = $urandom_range(1, 2);
            send_random_pixels(frames * cur_w * cur_h);
            settle();
        end
    endtask

    initial begin : result_sink
        int unsigned gap;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = (results_taken == 40 || results_taken == 2500) ? HOLD_CYCLES
                                                                 : next_gap(1);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            results_taken++;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = get_pkg::REG_THRESHOLD;
        cfg_wr_data = '0;
        pixels_sent = 0;
        results_taken = 0;
        phases = 0;
        calm[0] = 0;
        calm[1] = 0;
        cur_w = 640;
        cur_h = 480;
        pix_mode = 0;
        base_level = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_UNUSED, 12'hA5C);
        set_config(8'd0, 12'd5, 12'd4);
        for (int i = 0; i < 20; i++)
            send_pixel(PROBE[i*8 +: 8]);
        settle();

        run_random(320);
        run_random(320);
        settle();

        $display("run covered %0d pixels over %0d register settings, %0d edge results compared",
                 pixels_sent, phases, checked);
        $display("including mid-frame shrinks, clamped sizes and long result back-pressure");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
